// ===== rtl/sdpe_pkg.sv =====
// Shared constants and beat types for the slot delta patch encoder.
package sdpe_pkg;

   localparam int SLOT_WORDS      = 16;
   localparam int SLOT_INDEX_BITS = 24;
   localparam int WORD_BYTES      = 4;
   localparam int POS_BITS        = $clog2(SLOT_WORDS + 1);

   localparam logic [31:0] RECORD_BYTES = 32'(WORD_BYTES + WORD_BYTES * SLOT_WORDS);
   localparam logic [POS_BITS-1:0] POS_FULL = POS_BITS'(SLOT_WORDS);
   localparam logic [POS_BITS-1:0] POS_ONE  = POS_BITS'(1);

   typedef enum logic [1:0] {
      KIND_INDEX = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_END   = 2'd2
   } word_kind_type;

   typedef struct packed {
      logic [31:0] current_word;
      logic [31:0] original_word;
      logic        last_word;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic [1:0]  word_kind;
      logic        run_end;
   } rsp_payload_type;

endpackage

// ===== rtl/sdpe_req_if.sv =====
// Input channel: image word pair plus last-word flag.
interface sdpe_req_if;
   import sdpe_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sdpe_rsp_if.sv =====
// Result channel: patch record words and the end beat.
interface sdpe_rsp_if;
   import sdpe_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sdpe_cell.sv =====
// One word cell of the slot shift chain.
module sdpe_cell (
   input  logic        clock,
   input  logic        shift,
   input  logic [31:0] word_in,
   output logic [31:0] word_out
);
   logic [31:0] word_ff;
   logic [31:0] word_in_mux;

   assign word_in_mux = shift ? word_in : word_ff;

   always_ff @(posedge clock) begin
      word_ff <= word_in_mux;
   end

   assign word_out = word_ff;
endmodule

// ===== rtl/slot_delta_patch_encoder_unit.sv =====
// Top level of the slot delta patch encoder: cell chain, sequencer, output register.
//
// Usage:
//   req_bus carries one word pair per beat (current word, original word, last flag).
//   rsp_bus carries record beats: the slot index, then all slot data words, and after
//   the final image word one end beat with the saturated patch byte total.
//   Words enter a chain of 16 cells at the tail; each cell hands its word to its
//   neighbor on every shift, and the head cell feeds the output.
//   A word that does not close a slot, or closes an unchanged one, is taken and
//   yields nothing. A slot that closes with a difference is streamed out at one beat
//   per cycle while rsp_bus is ready: a partial slot first shifts zeros in until the
//   chain holds 16 words, then 17 beats follow, plus one end beat after the final word.
//   After the closing word and any padding, the sequencer enters its index state and
//   writes the index beat into the output register once that register is free.
//   Input is taken only while no record is being streamed.
//   Reset (synchronous, active high) clears position, slot index, difference flag and
//   total; cell contents are not cleared and never reach the output unwritten.
//   When rsp_bus stalls, the output register holds its beat and the sequencer waits before writing the next one.
module slot_delta_patch_encoder_unit (
   input logic clock,
   input logic reset,
   sdpe_req_if.sink   req_bus,
   sdpe_rsp_if.source rsp_bus
);
   import sdpe_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_INDEX = 5'b00100,
      ST_DATA  = 5'b01000,
      ST_END   = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [POS_BITS-1:0]        pos_ff, pos_in;
   logic [SLOT_INDEX_BITS-1:0] slot_ff, slot_in;
   logic                       differs_ff, differs_in;
   logic [31:0]                total_ff, total_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       out_free;
   logic                       shift;
   logic [31:0]                tail_word;
   logic [POS_BITS-1:0]        pos_next;
   logic                       differs_next;
   logic [32:0]                total_sum;
   logic [31:0]                cell_word [SLOT_WORDS+1];

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign pos_next     = pos_ff + POS_ONE;
   assign differs_next = differs_ff ||
                         (req_bus.payload.current_word != req_bus.payload.original_word);
   assign total_sum    = {1'b0, total_ff} + {1'b0, RECORD_BYTES};

   // tail gets the image word on accept, zeros while padding or draining
   assign tail_word = accept ? req_bus.payload.current_word : 32'd0;
   assign cell_word[SLOT_WORDS] = tail_word;

   for (genvar i = 0; i < SLOT_WORDS; i++) begin : g_cell
      sdpe_cell u_cell (
         .clock    (clock),
         .shift    (shift),
         .word_in  (cell_word[i+1]),
         .word_out (cell_word[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      differs_in   = differs_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      shift        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               shift = 1'b1;
               if (pos_next == POS_FULL || req_bus.payload.last_word) begin
                  if (differs_next) begin
                     last_in  = req_bus.payload.last_word;
                     pos_in   = pos_next;
                     state_in = (pos_next == POS_FULL) ? ST_INDEX : ST_PAD;
                  end else begin
                     slot_in    = slot_ff + SLOT_INDEX_BITS'(1);
                     pos_in     = '0;
                     differs_in = 1'b0;
                     state_in   = req_bus.payload.last_word ? ST_END : ST_IDLE;
                  end
               end else begin
                  pos_in     = pos_next;
                  differs_in = differs_next;
               end
            end
         end
         ST_PAD: begin
            shift  = 1'b1;
            pos_in = pos_next;
            if (pos_next == POS_FULL) begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_word  = 32'(slot_ff);
               rsp_data_in.word_kind = KIND_INDEX;
               rsp_data_in.run_end   = 1'b0;
               total_in = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
               slot_in  = slot_ff + SLOT_INDEX_BITS'(1);
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               shift                 = 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_word  = cell_word[0];
               rsp_data_in.word_kind = KIND_DATA;
               rsp_data_in.run_end   = (pos_ff == POS_ONE) && !last_ff;
               pos_in = pos_ff - POS_ONE;
               if (pos_ff == POS_ONE) begin
                  differs_in = 1'b0;
                  state_in   = last_ff ? ST_END : ST_IDLE;
               end
            end
         end
         ST_END: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_word  = total_ff;
               rsp_data_in.word_kind = KIND_END;
               rsp_data_in.run_end   = 1'b1;
               // image done: back to a fresh image at slot 0
               pos_in     = '0;
               slot_in    = '0;
               differs_in = 1'b0;
               total_in   = '0;
               last_in    = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         slot_ff      <= '0;
         differs_ff   <= 1'b0;
         total_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         differs_ff   <= differs_in;
         total_ff     <= total_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;
endmodule

// ===== verif/tb_slot_delta_patch_encoder_unit.sv =====
// Self-checking testbench for slot_delta_patch_encoder_unit: directed and random images.
module tb_slot_delta_patch_encoder_unit;
   import sdpe_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int TAIL_CYCLES = 100;
   localparam int RANDOM_ITEMS_PER_PHASE = 48;

   logic clock;
   logic reset;

   sdpe_req_if req_bus ();
   sdpe_rsp_if rsp_bus ();

   slot_delta_patch_encoder_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted image state
   logic [31:0]                img_slot_words [SLOT_WORDS];
   int                         img_fill;
   logic [SLOT_INDEX_BITS-1:0] img_slot_index;
   logic                       img_slot_dirty;
   logic [31:0]                img_patch_bytes;

   rsp_payload_type pending_beats [$];
   int              error_count;
   int              send_idle_pct;
   int              rsp_stall_pct;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (pending_beats.size() == 0) begin
            $error("unexpected beat: out_word %h word_kind %0d run_end %0d",
                   got.out_word, got.word_kind, got.run_end);
            error_count++;
         end else begin
            want = pending_beats.pop_front();
            if (got.out_word !== want.out_word) begin
               $error("out_word expected %h actual %h", want.out_word, got.out_word);
               error_count++;
            end
            if (got.word_kind !== want.word_kind) begin
               $error("word_kind expected %0d actual %0d", want.word_kind, got.word_kind);
               error_count++;
            end
            if (got.run_end !== want.run_end) begin
               $error("run_end expected %0d actual %0d", want.run_end, got.run_end);
               error_count++;
            end
         end
      end
   end

   task automatic clear_image_state();
      for (int j = 0; j < SLOT_WORDS; j++) img_slot_words[j] = '0;
      img_fill = 0;
      img_slot_index = '0;
      img_slot_dirty = 1'b0;
      img_patch_bytes = '0;
   endtask

   task automatic predict_patch_beats(input logic [31:0] cur, input logic [31:0] orig,
                                      input logic last);
      rsp_payload_type item_beats [$];
      rsp_payload_type beat;
      logic [32:0]     sum;
      if (img_fill < SLOT_WORDS) begin
         img_slot_words[img_fill] = cur;
         img_fill++;
      end
      if (cur != orig) img_slot_dirty = 1'b1;
      if (img_fill >= SLOT_WORDS || last) begin
         if (img_slot_dirty) begin
            beat.out_word = 32'(img_slot_index);
            beat.word_kind = KIND_INDEX;
            beat.run_end = 1'b0;
            item_beats.push_back(beat);
            for (int j = 0; j < SLOT_WORDS; j++) begin
               // positions past the fill are zero padding
               beat.out_word = (j < img_fill) ? img_slot_words[j] : 32'd0;
               beat.word_kind = KIND_DATA;
               item_beats.push_back(beat);
            end
            sum = {1'b0, img_patch_bytes} + 33'(WORD_BYTES) + 33'(WORD_BYTES * SLOT_WORDS);
            img_patch_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         end
         img_slot_index = img_slot_index + SLOT_INDEX_BITS'(1);
         img_fill = 0;
         img_slot_dirty = 1'b0;
      end
      if (last) begin
         beat.out_word = img_patch_bytes;
         beat.word_kind = KIND_END;
         beat.run_end = 1'b0;
         item_beats.push_back(beat);
         clear_image_state();
      end
      if (item_beats.size() > 0) item_beats[item_beats.size() - 1].run_end = 1'b1;
      foreach (item_beats[k]) pending_beats.push_back(item_beats[k]);
   endtask

   // One beat on the request side; valid stays high for a back-to-back follower.
   task automatic send_word(input logic [31:0] cur, input logic [31:0] orig, input logic last);
      req_payload_type pl;
      int              gap;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      pl.current_word = cur;
      pl.original_word = orig;
      pl.last_word = last;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.payload <= pl;
      do @(posedge clock); while (!req_bus.ready);
      predict_patch_beats(cur, orig, last);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] differing_word(input logic [31:0] cur);
      logic [31:0] orig;
      if ($urandom_range(0, 1) == 0) begin
         orig = $urandom;
         if (orig == cur) orig = cur ^ 32'd1;
      end else begin
         orig = cur ^ (32'd1 << $urandom_range(0, 31));
      end
      return orig;
   endfunction

   task automatic test_unchanged_single_word();
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_partial_slot_padding();
      logic [31:0] w;
      w = $urandom;
      send_word(w, w, 1'b0);
      send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      w = $urandom;
      send_word(w, w, 1'b1);
   endtask

   // Changed full slot closes on its own, then a clean one-word tail ends the image.
   task automatic test_full_slot_then_clean_tail();
      logic [31:0] w;
      for (int j = 0; j < SLOT_WORDS - 1; j++) begin
         w = $urandom;
         send_word(w, w, 1'b0);
      end
      send_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      w = $urandom;
      send_word(w, w, 1'b1);
   endtask

   task automatic send_random_image(output int words_sent);
      int          len;
      int          mode;
      int          roll;
      logic [31:0] cur;
      logic [31:0] orig;
      logic        hit;
      roll = $urandom_range(0, 99);
      if (roll < 65)      len = $urandom_range(1, 20);
      else if (roll < 85) len = SLOT_WORDS * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
      else                len = $urandom_range(1, 3 * SLOT_WORDS);
      if (len < 1) len = 1;
      mode = $urandom_range(0, 3);
      for (int j = 0; j < len; j++) begin
         cur = $urandom;
         case (mode)
            0: hit = 1'b0;
            1: hit = ($urandom_range(0, 7) == 0);
            default: hit = ($urandom_range(0, 1) == 0);
         endcase
         orig = hit ? differing_word(cur) : cur;
         send_word(cur, orig, j == len - 1);
      end
      words_sent = len;
   endtask

   task automatic test_random_images(input int n_items, input int send_pct, input int stall_pct);
      int sent;
      int len;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         send_random_image(len);
         sent += len;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      error_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      clear_image_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unchanged_single_word();
      test_partial_slot_padding();
      test_full_slot_then_clean_tail();
      wait_all_results();

      test_random_images(RANDOM_ITEMS_PER_PHASE, 0, 0);
      test_random_images(RANDOM_ITEMS_PER_PHASE, 47, 0);
      wait_all_results();
      test_random_images(RANDOM_ITEMS_PER_PHASE, 0, 47);
      test_random_images(RANDOM_ITEMS_PER_PHASE, 31, 31);

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_beats.size() != 0) begin
         $error("%0d expected beats never arrived", pending_beats.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
